// ----- rtl/ptbd_pkg.sv -----
// shared types, widths and register codes of the point to box distance block
`timescale 1ns / 1ps

package ptbd_pkg;

    // coordinate width of points and box bounds (Q8.8 at 16)
    localparam int COORD_WIDTH = 16;
    // width of the distance result
    localparam int DIST_WIDTH  = 17;

    // sum of three squares before and after saturation at 64 bits
    localparam int FULL_W = 2 * COORD_WIDTH + 2;
    localparam int SUM_W  = (FULL_W > 64) ? 64 : FULL_W;
    // square root widths: root bits, radicand bits, partial remainder bits
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // stream and register port widths
    localparam int IN_W   = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_W  = ((DIST_WIDTH + 7) / 8) * 8;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // box bounds, index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } box_t;

    // word handed from cell to cell along the square root chain
    typedef struct packed {
        logic              in_box;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } root_stage_t;

endpackage

// ----- rtl/ptbd_front.sv -----
// gap, square and sum stages ahead of the square root chain
`timescale 1ns / 1ps

module ptbd_front
    import ptbd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  box_t         box,
    input  logic         in_valid,
    output logic         in_ready,
    input  coord_t [2:0] point,
    output logic         out_valid,
    input  logic         out_ready,
    output root_stage_t  out_data
);

    localparam logic [FULL_W-1:0] SAT_MAX = {FULL_W{1'b1}} >> (FULL_W - SUM_W);

    logic                         gap_valid_reg;
    logic [2:0][COORD_WIDTH-1:0]  gap_reg;
    logic [2:0][COORD_WIDTH-1:0]  gap_next;
    logic                         gap_inside_reg;
    logic                         gap_inside_next;

    logic                         sq_valid_reg;
    logic [2:0][2*COORD_WIDTH-1:0] sq_reg;
    logic                         sq_inside_reg;

    logic                         sum_valid_reg;
    root_stage_t                  sum_reg;
    root_stage_t                  sum_next;

    logic gap_ready;
    logic sq_ready;
    logic sum_ready;

    logic signed [COORD_WIDTH:0] q_ext [3];
    logic signed [COORD_WIDTH:0] lo_ext [3];
    logic signed [COORD_WIDTH:0] hi_ext [3];
    logic signed [COORD_WIDTH:0] d_lo [3];
    logic signed [COORD_WIDTH:0] d_hi [3];
    logic [FULL_W-1:0] sum_full;
    logic [FULL_W-1:0] sum_sat;

    // a stage takes a new transaction when empty or when its own moves on
    assign sum_ready = !sum_valid_reg || out_ready;
    assign sq_ready  = !sq_valid_reg  || sum_ready;
    assign gap_ready = !gap_valid_reg || sq_ready;
    assign in_ready  = gap_ready;

    // per-axis gap, lower bound tested first
    always_comb begin
        gap_inside_next = 1'b1;
        for (int a = 0; a < 3; a++) begin
            q_ext[a]  = {point[a][COORD_WIDTH-1], point[a]};
            lo_ext[a] = {box.lo[a][COORD_WIDTH-1], box.lo[a]};
            hi_ext[a] = {box.hi[a][COORD_WIDTH-1], box.hi[a]};
            d_lo[a]   = lo_ext[a] - q_ext[a];
            d_hi[a]   = q_ext[a] - hi_ext[a];
            if (q_ext[a] < lo_ext[a]) begin
                gap_next[a]     = d_lo[a][COORD_WIDTH-1:0];
                gap_inside_next = 1'b0;
            end else if (q_ext[a] > hi_ext[a]) begin
                gap_next[a]     = d_hi[a][COORD_WIDTH-1:0];
                gap_inside_next = 1'b0;
            end else begin
                gap_next[a] = '0;
            end
        end
    end

    // saturating sum of squares, loaded as the radicand of the chain
    always_comb begin
        sum_full = FULL_W'(sq_reg[0]) + FULL_W'(sq_reg[1]) + FULL_W'(sq_reg[2]);
        sum_sat  = (sum_full > SAT_MAX) ? SAT_MAX : sum_full;
        sum_next.in_box = sq_inside_reg;
        sum_next.rem    = '0;
        sum_next.root   = '0;
        sum_next.rad    = RAD_W'(sum_sat[SUM_W-1:0]);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            if (gap_ready) gap_valid_reg <= in_valid;
            if (sq_ready)  sq_valid_reg  <= gap_valid_reg;
            if (sum_ready) sum_valid_reg <= sq_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (gap_ready) begin
            gap_reg        <= gap_next;
            gap_inside_reg <= gap_inside_next;
        end
        if (sq_ready) begin
            for (int a = 0; a < 3; a++) begin
                sq_reg[a] <= gap_reg[a] * gap_reg[a];
            end
            sq_inside_reg <= gap_inside_reg;
        end
        if (sum_ready) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_data  = sum_reg;

endmodule

// ----- rtl/ptbd_sqrt_cell.sv -----
// one cell of the square root chain, settles one root bit per transaction
`timescale 1ns / 1ps

module ptbd_sqrt_cell
    import ptbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  root_stage_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output root_stage_t out_data
);

    logic        valid_reg;
    root_stage_t data_reg;
    root_stage_t data_next;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;

    assign in_ready = !valid_reg || out_ready;

    // bring down two radicand bits and try a one in the next root place
    always_comb begin
        rem_shift = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1:RAD_W-2]};
        trial     = {in_data.root, 2'b01};
        data_next.in_box = in_data.in_box;
        data_next.rad    = {in_data.rad[RAD_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
            data_next.rem  = rem_shift - trial;
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = rem_shift;
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/point_to_box_distance.sv -----
// top level: register port, front stages and square root cell chain
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_tvalid/tready  | s_tdata: point_x, point_y, point_z
//  m_      | out       | m_tvalid/tready  | m_tdata: distance, m_tuser: inside_res
//  apb     | in        | psel/penable     | box bounds at 0x00..0x14
//
// one point enters per cycle while the output is not stalled; its result passes
// through the gap, square and sum stages and then through one square root cell
// per root bit
// synchronous active-low reset empties every stage and clears the box to zero
// each stage holds when its successor is full and stalled, so bubbles close up

`timescale 1ns / 1ps

module point_to_box_distance
    import ptbd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // point_x [15:0], point_y [31:16], point_z [47:32]
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // distance [16:0]
    output logic [OUT_W-1:0]  m_tdata,
    // inside_res [0]
    output logic              m_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    box_t          box_reg;
    coord_t [2:0]  point;
    logic [IDX_W-1:0] reg_idx;
    logic          cfg_write;

    logic          chain_valid [ROOT_W+1];
    logic          chain_ready [ROOT_W+1];
    root_stage_t   chain_data  [ROOT_W+1];

    // register port, always ready
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_MIN_X: box_reg.lo[0] <= pwdata[COORD_WIDTH-1:0];
                REG_MIN_Y: box_reg.lo[1] <= pwdata[COORD_WIDTH-1:0];
                REG_MIN_Z: box_reg.lo[2] <= pwdata[COORD_WIDTH-1:0];
                REG_MAX_X: box_reg.hi[0] <= pwdata[COORD_WIDTH-1:0];
                REG_MAX_Y: box_reg.hi[1] <= pwdata[COORD_WIDTH-1:0];
                REG_MAX_Z: box_reg.hi[2] <= pwdata[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // read back, sign extended
    always_comb begin
        unique case (reg_idx)
            REG_MIN_X: prdata = 32'(box_reg.lo[0]);
            REG_MIN_Y: prdata = 32'(box_reg.lo[1]);
            REG_MIN_Z: prdata = 32'(box_reg.lo[2]);
            REG_MAX_X: prdata = 32'(box_reg.hi[0]);
            REG_MAX_Y: prdata = 32'(box_reg.hi[1]);
            REG_MAX_Z: prdata = 32'(box_reg.hi[2]);
            default:   prdata = '0;
        endcase
    end

    // unpack the point
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            point[a] = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    ptbd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .box       (box_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .point     (point),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // square root chain, most significant root bit first
    for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
        ptbd_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // result transaction
    assign chain_ready[ROOT_W] = m_tready;
    assign m_tvalid = chain_valid[ROOT_W];
    assign m_tuser  = chain_data[ROOT_W].in_box;
    assign m_tdata  = OUT_W'(DIST_WIDTH'(chain_data[ROOT_W].root));

endmodule

// ----- test/tb.sv -----
// self-checking testbench of the point to box distance block
`timescale 1ns / 1ps

module tb;
    import ptbd_pkg::*;

    // pipeline depth of the block and the watchdog limit in idle cycles
    localparam int PIPE_LAT   = 3 + ROOT_W;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_PHASES = 6;
    localparam int RAND_ITEMS  = 92;

    typedef struct {
        logic                  in_box;
        logic [DIST_WIDTH-1:0] dist_val;
    } result_t;

    typedef enum int {BOX_PLAIN, BOX_SMALL, BOX_INVERTED, BOX_FLAT, BOX_WIDE} box_kind_e;
    typedef enum int {PT_ANY, PT_NEAR, PT_INNER} point_kind_e;

    // expected results of accepted points, predicted from a private copy of the box
    class distance_scoreboard;
        coord_t      lo [3];
        coord_t      hi [3];
        result_t     expected_dist [$];
        int unsigned fail_count;

        function new();
            for (int a = 0; a < 3; a++) begin
                lo[a] = '0;
                hi[a] = '0;
            end
            fail_count = 0;
        endfunction

        function void set_bound(input logic [IDX_W-1:0] idx, input coord_t v);
            case (idx)
                REG_MIN_X: lo[0] = v;
                REG_MIN_Y: lo[1] = v;
                REG_MIN_Z: lo[2] = v;
                REG_MAX_X: hi[0] = v;
                REG_MAX_Y: hi[1] = v;
                REG_MAX_Z: hi[2] = v;
                default: ;
            endcase
        endfunction

        // bitwise floor square root, two radicand bits per step
        function logic [DIST_WIDTH-1:0] floor_root(input longint unsigned n);
            longint unsigned root;
            longint unsigned probe;
            longint unsigned rest;
            root  = 0;
            rest  = n;
            probe = 64'h4000_0000_0000_0000;
            while (probe > rest) probe = probe >> 2;
            while (probe != 0) begin
                if (rest >= root + probe) begin
                    rest = rest - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root[DIST_WIDTH-1:0];
        endfunction

        // per-axis gap, sum of squares and floor root; inverted axes test below first
        function result_t predict_distance(input logic [IN_W-1:0] word);
            int              q;
            int              l;
            int              h;
            longint unsigned gap;
            longint unsigned total;
            result_t         r;
            r.in_box = 1'b1;
            total    = 0;
            for (int a = 0; a < 3; a++) begin
                q = coord_t'(word[a*COORD_WIDTH +: COORD_WIDTH]);
                l = lo[a];
                h = hi[a];
                if (q < l || q > h) r.in_box = 1'b0;
                if (q < l) gap = l - q;
                else if (q > h) gap = q - h;
                else gap = 0;
                total = total + gap * gap;
            end
            r.dist_val = r.in_box ? '0 : floor_root(total);
            return r;
        endfunction

        function void note_point(input logic [IN_W-1:0] word);
            expected_dist.push_back(predict_distance(word));
        endfunction

        function void check_result(input logic [OUT_W-1:0] tdata, input logic tuser);
            result_t want;
            if (expected_dist.size() == 0) begin
                $error("result transaction with no point waiting: tdata %h tuser %b",
                       tdata, tuser);
                fail_count++;
                return;
            end
            want = expected_dist.pop_front();
            if (tuser !== want.in_box) begin
                $error("inside_res: expected %0d, actual %0d", want.in_box, tuser);
                fail_count++;
            end
            if (tdata[DIST_WIDTH-1:0] !== want.dist_val) begin
                $error("distance: expected %0d, actual %0d", want.dist_val,
                       tdata[DIST_WIDTH-1:0]);
                fail_count++;
            end
            if (tdata[OUT_W-1:DIST_WIDTH] !== '0) begin
                $error("tdata padding: expected 0, actual %h", tdata[OUT_W-1:DIST_WIDTH]);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_dist.size();
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    // point_x [15:0], point_y [31:16], point_z [47:32]
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // distance [16:0]
    logic [OUT_W-1:0]  m_tdata;
    // inside_res [0]
    logic              m_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    distance_scoreboard sb = new();

    coord_t box_lo [3];
    coord_t box_hi [3];
    int     burst_left  = 0;
    int     stall_mode  = 0;
    int     stall_left  = 0;
    int     idle_cycles = 0;

    point_to_box_distance u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // monitor both streams
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_point(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // receiver back-pressure: modes of free flow, random, sparse and long stalls
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_left % 32 == 0);
        endcase
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                     (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one register write: setup then access, psel left high for a following write
    task automatic apb_write(input logic [IDX_W-1:0] idx, input coord_t v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {{(32-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_bound(idx, v);
    endtask

    // drain the pipeline, then load all six bounds
    task automatic set_box(input coord_t lx, input coord_t ly, input coord_t lz,
                           input coord_t hx, input coord_t hy, input coord_t hz);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        apb_write(REG_MIN_X, lx);
        apb_write(REG_MIN_Y, ly);
        apb_write(REG_MIN_Z, lz);
        apb_write(REG_MAX_X, hx);
        apb_write(REG_MAX_Y, hy);
        apb_write(REG_MAX_Z, hz);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        box_lo[0] = lx; box_lo[1] = ly; box_lo[2] = lz;
        box_hi[0] = hx; box_hi[1] = hy; box_hi[2] = hz;
        @(posedge aclk);
    endtask

    // one input transaction; bursts of random length separated by random gaps
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
        logic [IN_W-1:0] word;
        word = '0;
        word[0*COORD_WIDTH +: COORD_WIDTH] = x;
        word[1*COORD_WIDTH +: COORD_WIDTH] = y;
        word[2*COORD_WIDTH +: COORD_WIDTH] = z;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    function automatic coord_t clamp_coord(input int v);
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return coord_t'(v);
    endfunction

    // random box of one of several shapes
    task automatic pick_random_box();
        int        lv [3];
        int        hv [3];
        int        c;
        int        half;
        int        t;
        box_kind_e kind;
        kind = box_kind_e'($urandom_range(0, 4));
        for (int a = 0; a < 3; a++) begin
            lv[a] = int'($urandom_range(0, 65535)) - 32768;
            hv[a] = int'($urandom_range(0, 65535)) - 32768;
            case (kind)
                BOX_PLAIN: begin
                    if (lv[a] > hv[a]) begin
                        t = lv[a]; lv[a] = hv[a]; hv[a] = t;
                    end
                end
                BOX_SMALL: begin
                    c     = lv[a];
                    half  = $urandom_range(0, 512);
                    lv[a] = clamp_coord(c - half);
                    hv[a] = clamp_coord(c + half);
                end
                BOX_INVERTED: begin
                    if ((lv[a] < hv[a]) == ($urandom_range(0, 1) == 1)) begin
                        t = lv[a]; lv[a] = hv[a]; hv[a] = t;
                    end
                end
                BOX_FLAT: begin
                    hv[a] = lv[a];
                end
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        lv[a] = -32768;
                        hv[a] = 32767;
                    end else if (lv[a] > hv[a]) begin
                        t = lv[a]; lv[a] = hv[a]; hv[a] = t;
                    end
                end
            endcase
        end
        set_box(coord_t'(lv[0]), coord_t'(lv[1]), coord_t'(lv[2]),
                coord_t'(hv[0]), coord_t'(hv[1]), coord_t'(hv[2]));
    endtask

    // random point: anywhere, near a bound, or inside the box
    task automatic send_random_point();
        int          q [3];
        int          b;
        point_kind_e kind;
        for (int a = 0; a < 3; a++) begin
            kind = point_kind_e'($urandom_range(0, 9) < 4 ? PT_ANY :
                                 ($urandom_range(0, 5) < 4 ? PT_NEAR : PT_INNER));
            case (kind)
                PT_NEAR: begin
                    b    = ($urandom_range(0, 1) == 1) ? int'(box_lo[a]) : int'(box_hi[a]);
                    q[a] = b + int'($urandom_range(0, 8)) - 4;
                end
                PT_INNER: begin
                    if (box_lo[a] <= box_hi[a])
                        q[a] = int'(box_lo[a]) +
                               int'($urandom_range(0, int'(box_hi[a]) - int'(box_lo[a])));
                    else
                        q[a] = int'($urandom_range(0, 65535));
                end
                default: q[a] = int'($urandom_range(0, 65535));
            endcase
        end
        send_point(coord_t'(q[0]), coord_t'(q[1]), coord_t'(q[2]));
    endtask

    // stimulus
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(0, 20);

        // degenerate box at the origin straight out of reset
        box_lo[0] = '0; box_lo[1] = '0; box_lo[2] = '0;
        box_hi[0] = '0; box_hi[1] = '0; box_hi[2] = '0;
        send_point(0, 0, 0);
        send_point(1, -1, 0);
        send_point(-32768, 0, 0);

        // unit cube: surface points, single-axis misses, extreme points
        set_box(-256, -256, -256, 256, 256, 256);
        send_point(0, 0, 0);
        send_point(256, 256, 256);
        send_point(-256, -256, -256);
        send_point(256, 0, 0);
        send_point(-256, 256, 0);
        send_point(257, 0, 0);
        send_point(0, -257, 0);
        send_point(0, 0, 300);
        send_point(-32768, -32768, -32768);
        send_point(32767, 32767, 32767);
        send_point(-32768, 32767, 0);
        send_point(21845, -21846, 10922);

        // fully inverted box at the extremes gives the largest gaps
        set_box(32767, 32767, 32767, -32768, -32768, -32768);
        send_point(-32768, -32768, -32768);
        send_point(32767, 32767, 32767);
        send_point(0, 0, 0);
        send_point(-32768, 32767, 0);

        // box covering the whole range
        set_box(-32768, -32768, -32768, 32767, 32767, 32767);
        send_point(-32768, 32767, 0);
        send_point(32767, -32768, 12345);

        // inverted on x only: where both tests hit, the below-min test decides the gap
        set_box(100, -256, -256, -100, 256, 256);
        send_point(0, 0, 0);
        send_point(-100, 0, 0);
        send_point(100, 0, 0);

        // random boxes and points
        for (int p = 0; p < RAND_PHASES; p++) begin
            pick_random_box();
            for (int i = 0; i < RAND_ITEMS; i++) send_random_point();
        end

        // drain and finish
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 20) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ptbd_pkg.sv
rtl/ptbd_front.sv
rtl/ptbd_sqrt_cell.sv
rtl/point_to_box_distance.sv
test/tb.sv
